// File: sv/lru_kv_pkg.sv
// shared types and constants for the lru key-value cache
// no dependencies; imported by every module of the block
package lru_kv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } lru_kv_req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } lru_kv_rsp_t;

endpackage

// File: sv/lru_kv_match.sv
// parallel key compare across all table entries
// depends on lru_kv_pkg
module lru_kv_match #(
  parameter int ENTRIES = 16
) (
  input  logic [lru_kv_pkg::KEY_W-1:0] key,
  input  logic [lru_kv_pkg::KEY_W-1:0] entry_keys [ENTRIES],
  input  logic [ENTRIES-1:0]           entry_valid,
  output logic                         hit,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_idx
);
  import lru_kv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // valid keys are unique, so at most one entry matches
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_valid[i] && entry_keys[i] == key) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

endmodule

// File: sv/lru_kv_table.sv
// entry storage, recency ranks and occupancy, updated when go is high
// depends on lru_kv_pkg and lru_kv_match
module lru_kv_table #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  lru_kv_pkg::lru_kv_req_t       req,
  input  logic [lru_kv_pkg::CAP_W-1:0]  capacity,
  output lru_kv_pkg::lru_kv_rsp_t       rsp
);
  import lru_kv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int AW = ((OW > CAP_W) ? OW : CAP_W) + 1;

  logic [KEY_W-1:0] keys   [ENTRIES];
  logic [VAL_W-1:0] values [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [RW-1:0]      rank [ENTRIES];
  logic [OW-1:0]      occ;

  logic [ENTRIES-1:0] valid_next;
  logic [RW-1:0]      rank_next [ENTRIES];
  logic [OW-1:0]      occ_next;

  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [RW-1:0] hit_rank;
  logic [AW-1:0] cap_ext;
  logic [AW-1:0] cap_eff;
  logic          evict;
  logic [ENTRIES-1:0] keep;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] wr_idx;
  logic [OW-1:0] occ_kept;

  lru_kv_match #(.ENTRIES(ENTRIES)) u_match (
    .key         (req.key),
    .entry_keys  (keys),
    .entry_valid (valid),
    .hit         (hit),
    .hit_idx     (hit_idx)
  );

  // capacity clamped to 1..ENTRIES
  always_comb begin
    cap_ext = AW'(capacity);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = AW'(1);
    end else if (cap_ext > AW'(ENTRIES)) begin
      cap_eff = AW'(ENTRIES);
    end
  end

  // ranks are dense, so evicting down to cap-1 drops every rank >= cap-1
  always_comb begin
    evict = AW'(occ) >= cap_eff;
    for (int i = 0; i < ENTRIES; i++) begin
      keep[i] = valid[i] && !(evict && AW'(rank[i]) >= (cap_eff - AW'(1)));
    end
    occ_kept = evict ? OW'(cap_eff - AW'(1)) : occ;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!keep[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    hit_rank   = rank[hit_idx];
    valid_next = valid;
    rank_next  = rank;
    occ_next   = occ;
    if (hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid[i] && rank[i] < hit_rank) begin
          rank_next[i] = rank[i] + RW'(1);
        end
      end
      rank_next[hit_idx] = '0;
    end else if (req.command == CMD_SET) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank_next[i] = keep[i] ? rank[i] + RW'(1) : '0;
      end
      valid_next           = keep;
      valid_next[free_idx] = 1'b1;
      rank_next[free_idx]  = '0;
      occ_next             = occ_kept + OW'(1);
    end
  end

  assign wr_idx = hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (go) begin
      valid <= valid_next;
      occ   <= occ_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && req.command == CMD_SET) begin
      keys[wr_idx]   <= req.key;
      values[wr_idx] <= req.value;
    end
  end

  always_comb begin
    rsp.found = hit;
    if (req.command == CMD_SET) begin
      rsp.read_value = req.value;
    end else if (hit) begin
      rsp.read_value = values[hit_idx];
    end else begin
      rsp.read_value = '0;
    end
  end

endmodule

// File: sv/lru_key_value_cache.sv
// top level of the lru key-value cache: request and result registers, capacity register
// depends on lru_kv_pkg and lru_kv_table
// a request passes the request register, then its result the result register, which loads only when empty or taken
// throughput: one request per cycle while m_tready holds; lookup is combinational, the table updates on advance
// reset: synchronous, clears valid bits, ranks, occupancy and the valid flags of both registers
// capacity returns to 16 on reset; no clearing pass, accepts requests right after reset
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key[31:0], value[63:32]
  input  logic [0:0]  s_tuser,   // command[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_value[31:0]
  output logic [0:0]  m_tuser,   // found[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lru_kv_pkg::CAP_W-1:0] cfg_data
);
  import lru_kv_pkg::*;

  logic              in_valid;
  lru_kv_req_t       in_req;
  logic              out_valid;
  lru_kv_rsp_t       out_rsp;
  lru_kv_rsp_t       rsp_next;
  logic [CAP_W-1:0]  capacity;
  logic              advance;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.command <= s_tuser[0];
      in_req.key     <= s_tdata[31:0];
      in_req.value   <= s_tdata[63:32];
    end
  end

  lru_kv_table #(.ENTRIES(ENTRIES)) u_table (
    .clk      (clk),
    .rst      (rst),
    .go       (advance),
    .req      (in_req),
    .capacity (capacity),
    .rsp      (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= rsp_next;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_rsp.read_value;
  assign m_tuser[0] = out_rsp.found;

endmodule
